@@ hw/rtl/tcsw_pkg.sv @@
// shared types, constants and command table for the text commanded square wave
`default_nettype none

package tcsw_pkg;

    localparam int BYTE_W    = 8;
    localparam int RATE_W    = 27;
    localparam int FREQ_W    = 16;
    localparam int DUTY_W    = 7;
    localparam int STATUS_W  = 2;
    localparam int CMD_COUNT = 8;
    localparam int CMD_IDX_W = 3;
    localparam int CMD_MAX_LEN = 7;
    localparam int NUM_W     = RATE_W + DUTY_W;
    localparam int DEN_W     = 20;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int OUT_W     = 32;

    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_APPLIED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic [CMD_IDX_W-1:0] CMD_FREQ_UP1   = 3'd0;
    localparam logic [CMD_IDX_W-1:0] CMD_FREQ_DN1   = 3'd1;
    localparam logic [CMD_IDX_W-1:0] CMD_FREQ_UP2   = 3'd2;
    localparam logic [CMD_IDX_W-1:0] CMD_FREQ_DN2   = 3'd3;
    localparam logic [CMD_IDX_W-1:0] CMD_DUTY_UP5   = 3'd4;
    localparam logic [CMD_IDX_W-1:0] CMD_DUTY_DN5   = 3'd5;
    localparam logic [CMD_IDX_W-1:0] CMD_DUTY_UP10  = 3'd6;
    localparam logic [CMD_IDX_W-1:0] CMD_DUTY_DN10  = 3'd7;

    localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

    localparam logic [FREQ_W-1:0] FREQ_MIN   = 16'd1;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 16'd65535;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd10;
    localparam logic [DUTY_W-1:0] DUTY_MIN   = 7'd5;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd95;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;
    localparam logic [RATE_W-1:0] RATE_RESET = 27'd16000000;
    localparam logic [63:0]       HALF_RESET = 64'd8000000;

    typedef struct packed {
        logic step;
        logic apply;
        logic div_load;
        logic div_sel_off;
        logic div_step;
        logic store_on;
        logic store_off;
    } t_cmd;

    typedef struct packed {
        logic line_end;
        logic hit;
        logic div_busy;
    } t_sts;

    typedef struct packed {
        logic              wave;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
    } t_view;

    function automatic logic [8*CMD_MAX_LEN-1:0] cmd_text(input logic [CMD_IDX_W-1:0] idx);
        logic [8*CMD_MAX_LEN-1:0] t;
        case (idx)
            CMD_FREQ_UP1:  t = {"freq+1", 8'h00};
            CMD_FREQ_DN1:  t = {"freq-1", 8'h00};
            CMD_FREQ_UP2:  t = {"freq+2", 8'h00};
            CMD_FREQ_DN2:  t = {"freq-2", 8'h00};
            CMD_DUTY_UP5:  t = {"duty+5", 8'h00};
            CMD_DUTY_DN5:  t = {"duty-5", 8'h00};
            CMD_DUTY_UP10: t = "duty+10";
            CMD_DUTY_DN10: t = "duty-10";
            default:       t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [BYTE_W-1:0] cmd_char(input logic [CMD_IDX_W-1:0] idx,
                                                   input logic [2:0] pos);
        logic [8*CMD_MAX_LEN-1:0] t;
        t = cmd_text(idx);
        return t[8*(CMD_MAX_LEN-1-int'(pos)) +: 8];
    endfunction

    function automatic logic [2:0] cmd_len(input logic [CMD_IDX_W-1:0] idx);
        logic [2:0] n;
        case (idx)
            CMD_DUTY_UP10, CMD_DUTY_DN10: n = 3'd7;
            default:                      n = 3'd6;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tcsw_ctrl.sv @@
// controller state machine sequencing items, command updates and length divisions
`default_nettype none

module tcsw_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic                        i_out_free,
    input  wire tcsw_pkg::t_sts              i_sts,
    output tcsw_pkg::t_cmd                   o_cmd,
    output logic                             o_out_load,
    output logic [tcsw_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_idle
);
    import tcsw_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOAD_ON  = 3'd1;
    localparam logic [2:0] S_RUN_ON   = 3'd2;
    localparam logic [2:0] S_LOAD_OFF = 3'd3;
    localparam logic [2:0] S_RUN_OFF  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_load = 1'b0;
        o_status   = STATUS_NONE;
        o_idle     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_accept) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.line_end && i_sts.hit) begin
                        o_cmd.apply = 1'b1;
                        n_state     = S_LOAD_ON;
                    end else begin
                        o_out_load = 1'b1;
                        o_status   = i_sts.line_end ? STATUS_INVALID : STATUS_NONE;
                    end
                end
            end
            S_LOAD_ON: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_RUN_ON;
            end
            S_RUN_ON: begin
                if (i_sts.div_busy) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.store_on = 1'b1;
                    n_state        = S_LOAD_OFF;
                end
            end
            S_LOAD_OFF: begin
                o_cmd.div_load    = 1'b1;
                o_cmd.div_sel_off = 1'b1;
                n_state           = S_RUN_OFF;
            end
            S_RUN_OFF: begin
                if (i_sts.div_busy) begin
                    o_cmd.div_step = 1'b1;
                end else if (i_out_free) begin
                    o_cmd.store_off = 1'b1;
                    o_out_load      = 1'b1;
                    o_status        = STATUS_APPLIED;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tcsw_dp.sv @@
// datapath: line matcher, settings, phase counter and restoring length divider
`default_nettype none

module tcsw_dp #(
    parameter int LINE_CAPACITY    = 32,
    parameter int PHASE_COUNT_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [tcsw_pkg::RATE_W-1:0] i_cfg_wr_data,
    input  wire logic                        i_mode,
    input  wire logic [tcsw_pkg::BYTE_W-1:0] i_byte,
    input  wire tcsw_pkg::t_cmd              i_cmd,
    output tcsw_pkg::t_sts                   o_sts,
    output tcsw_pkg::t_view                  o_view
);
    import tcsw_pkg::*;

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam int PCB   = PHASE_COUNT_BITS;
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [63:0]      PH_TOP   = (64'd1 << PCB) - 64'd1;
    localparam logic [PCB-1:0]   PH_MAX   = '1;
    localparam logic [PCB-1:0]   PH_RESET = (HALF_RESET > PH_TOP) ? PH_MAX : PCB'(HALF_RESET);
    localparam logic [PCB-1:0]   PH_ONE   = PCB'(1);

    logic [RATE_W-1:0]    r_rate;
    logic [LEN_W-1:0]     r_len;
    logic [CMD_COUNT-1:0] r_cand;
    logic [FREQ_W-1:0]    r_freq;
    logic [DUTY_W-1:0]    r_duty;
    logic                 r_wave;
    logic [PCB-1:0]       r_phase;
    logic [PCB-1:0]       r_on;
    logic [PCB-1:0]       r_off;
    logic [NUM_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [CNT_W-1:0]     r_cnt;

    logic [LEN_W-1:0]     n_len;
    logic [CMD_COUNT-1:0] n_cand;
    logic [FREQ_W-1:0]    n_freq;
    logic [DUTY_W-1:0]    n_duty;
    logic                 n_wave;
    logic [PCB-1:0]       n_phase;

    logic                 printable;
    logic                 store_char;
    logic                 clear_line;
    logic [CMD_COUNT-1:0] match;
    logic [CMD_IDX_W-1:0] hit_idx;
    logic [DUTY_W-1:0]    duty_sel;
    logic [NUM_W-1:0]     prod;
    logic [DEN_W-1:0]     den;
    logic [DEN_W:0]       rem_shift;
    logic [DEN_W:0]       rem_diff;
    logic                 rem_ge;
    logic [PCB-1:0]       q_len;

    always_comb begin
        printable  = i_byte inside {[PRINT_LO:PRINT_HI]};
        store_char = i_cmd.step && !i_mode && printable && (r_len < LEN_LAST);
        clear_line = i_cmd.step && !i_mode && !printable;

        hit_idx = '0;
        for (int i = 0; i < CMD_COUNT; i++) begin
            match[i] = r_cand[i] && (r_len == LEN_W'(cmd_len(CMD_IDX_W'(i))));
            if (match[i]) begin
                hit_idx = CMD_IDX_W'(i);
            end
        end

        o_sts.line_end = !i_mode && !printable && (r_len != '0);
        o_sts.hit      = |match;
        o_sts.div_busy = (r_cnt != '0);
    end

    // candidate commands stay alive while every stored char matches their prefix
    always_comb begin
        n_len  = r_len;
        n_cand = r_cand;
        if (clear_line) begin
            n_len  = '0;
            n_cand = '1;
        end else if (store_char) begin
            n_len = r_len + LEN_W'(1);
            for (int i = 0; i < CMD_COUNT; i++) begin
                if ((r_len >= LEN_W'(cmd_len(CMD_IDX_W'(i)))) ||
                    (i_byte != cmd_char(CMD_IDX_W'(i), r_len[2:0]))) begin
                    n_cand[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_freq = r_freq;
        n_duty = r_duty;
        if (i_cmd.apply) begin
            case (hit_idx)
                CMD_FREQ_UP1:  n_freq = (r_freq == FREQ_MAX) ? FREQ_MAX : r_freq + 16'd1;
                CMD_FREQ_DN1:  n_freq = (r_freq <= 16'd1) ? FREQ_MIN : r_freq - 16'd1;
                CMD_FREQ_UP2:  n_freq = (r_freq >= 16'd65534) ? FREQ_MAX : r_freq + 16'd2;
                CMD_FREQ_DN2:  n_freq = (r_freq <= 16'd2) ? FREQ_MIN : r_freq - 16'd2;
                CMD_DUTY_UP5:  n_duty = (r_duty >= 7'd90) ? DUTY_MAX : r_duty + 7'd5;
                CMD_DUTY_DN5:  n_duty = (r_duty <= 7'd10) ? DUTY_MIN : r_duty - 7'd5;
                CMD_DUTY_UP10: n_duty = (r_duty >= 7'd85) ? DUTY_MAX : r_duty + 7'd10;
                CMD_DUTY_DN10: n_duty = (r_duty <= 7'd15) ? DUTY_MIN : r_duty - 7'd10;
                default: begin
                    n_freq = r_freq;
                    n_duty = r_duty;
                end
            endcase
        end
    end

    // divider operands and one restoring step
    always_comb begin
        duty_sel  = i_cmd.div_sel_off ? (DUTY_FULL - r_duty) : r_duty;
        prod      = NUM_W'(r_rate) * NUM_W'(duty_sel);
        den       = DEN_W'({r_freq, 3'b000}) + DEN_W'({r_freq, 1'b0});
        rem_shift = {r_rem, r_quo[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, r_den};
        rem_ge    = (rem_shift >= {1'b0, r_den});
        if (|r_quo[NUM_W-1:PCB]) begin
            q_len = PH_MAX;
        end else if (r_quo[PCB-1:0] == '0) begin
            q_len = PH_ONE;
        end else begin
            q_len = r_quo[PCB-1:0];
        end
    end

    always_comb begin
        n_wave  = r_wave;
        n_phase = r_phase;
        if (i_cmd.step && i_mode) begin
            if (r_phase <= PH_ONE) begin
                n_wave  = !r_wave;
                n_phase = r_wave ? r_off : r_on;
            end else begin
                n_phase = r_phase - PH_ONE;
            end
        end else if (i_cmd.store_off) begin
            n_phase = r_wave ? r_on : q_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= RATE_RESET;
            r_len   <= '0;
            r_cand  <= '1;
            r_freq  <= FREQ_RESET;
            r_duty  <= DUTY_RESET;
            r_wave  <= 1'b0;
            r_phase <= PH_RESET;
            r_on    <= PH_RESET;
            r_off   <= PH_RESET;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            r_len   <= n_len;
            r_cand  <= n_cand;
            r_freq  <= n_freq;
            r_duty  <= n_duty;
            r_wave  <= n_wave;
            r_phase <= n_phase;
            if (i_cmd.store_on) begin
                r_on <= q_len;
            end
            if (i_cmd.store_off) begin
                r_off <= q_len;
            end
            if (i_cmd.div_load) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= prod;
            r_rem <= '0;
            r_den <= den;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        end
    end

    always_comb begin
        o_view.wave = n_wave;
        o_view.freq = n_freq;
        o_view.duty = n_duty;
    end

endmodule

`default_nettype wire

@@ hw/rtl/text_commanded_square_wave.sv @@
// top level of the text commanded square wave generator with result register
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte, tuser[0] mode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: wave, freq, duty, status
// cfg       in   i_cfg_wr_en                   i_cfg_wr_data clock_rate_hz
//
// a tick, a printable byte, an empty or unknown line is finished in the cycle it is accepted
// an applied command runs through the request cycle, then load, the 34 quotient bits and
// store of the shared restoring divider, for on and off length; the last store waits for a free result register
// reset is synchronous and clears all control state
// input is held off while a command is in work or the result register is full and not being taken
`default_nettype none

module text_commanded_square_wave #(
    parameter int LINE_CAPACITY    = 32,
    parameter int PHASE_COUNT_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [tcsw_pkg::RATE_W-1:0] i_cfg_wr_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]                  s_axis_tuser,   // [0] mode
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [tcsw_pkg::OUT_W-1:0]       m_axis_tdata    // [0] wave_level,
                                                             // [16:1] freq_tenths,
                                                             // [23:17] duty_percent,
                                                             // [25:24] command_status
);
    import tcsw_pkg::*;

    localparam int PAD_W = OUT_W - 1 - FREQ_W - DUTY_W - STATUS_W;

    t_cmd                cmd;
    t_sts                sts;
    t_view               view;
    logic                out_load;
    logic [STATUS_W-1:0] status;
    logic                idle;
    logic                out_free;
    logic                accept;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = idle && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tcsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_out_load (out_load),
        .o_status   (status),
        .o_idle     (idle)
    );

    tcsw_dp #(
        .LINE_CAPACITY    (LINE_CAPACITY),
        .PHASE_COUNT_BITS (PHASE_COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_mode        (s_axis_tuser[0]),
        .i_byte        (s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_view        (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {PAD_W'(0), status, view.duty, view.freq, view.wave};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register loaded while a request still waits");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser[0]) |=> (m_axis_tvalid && m_axis_tdata[25:24] == STATUS_NONE))
        else $error("tick did not give a result in the next cycle");

    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:1] != 16'd0))
        else $error("frequency below floor");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:17] >= DUTY_MIN && m_axis_tdata[23:17] <= DUTY_MAX
                           && m_axis_tdata[25:24] != 2'd3))
        else $error("duty or status out of range");

endmodule

`default_nettype wire
